[hdl/yhpd_pkg.sv]
// shared types, constants and arctangent table for the yaw heading pd controller
package yhpd_pkg;

  localparam int POS_W     = 32;
  localparam int YAW_W     = 16;
  localparam int ERR_W     = 16;
  localparam int CMD_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_CW   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_BITS  = 30;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd1;

  localparam logic [GAIN_W-1:0] KP_RESET = 16'd3277;
  localparam logic [GAIN_W-1:0] KD_RESET = 16'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_CORD,
    ST_ANG,
    ST_WRAP,
    ST_SAT,
    ST_MUL,
    ST_FIN
  } yhpd_state_t;

  // atan(2^-k) in q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/yhpd_if.sv]
// valid/ready channel interfaces for position input and yaw command output
interface yhpd_in_if import yhpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] vehicle_x;
  logic signed [POS_W-1:0] vehicle_y;
  logic signed [YAW_W-1:0] vehicle_yaw;

  modport source(output valid, target_x, target_y, vehicle_x, vehicle_y, vehicle_yaw,
                 input ready);
  modport sink(input valid, target_x, target_y, vehicle_x, vehicle_y, vehicle_yaw,
               output ready);
endinterface

interface yhpd_out_if import yhpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] yaw_rate_cmd;
  logic signed [ERR_W-1:0] heading_error;

  modport source(output valid, yaw_rate_cmd, heading_error, input ready);
  modport sink(input valid, yaw_rate_cmd, heading_error, output ready);
endinterface

[hdl/yaw_heading_pd_controller.sv]
// yaw heading pd controller: cordic atan2, wrapped heading error, serial pd multiply
// an input beat passes through vector setup, the cordic iterations (one per cycle), angle,
//   wrap, saturation, operand load, bit-serial gain multiply and a final step to the result
// the next input beat is taken once the block is idle; a waiting result holds the final step
// reset (synchronous, rst_n low): idle, output empty, last error zero, kp 0.8, kd zero
module yaw_heading_pd_controller import yhpd_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  yhpd_in_if.sink              in_ch,
  yhpd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [GAIN_W-1:0]    cfg_data
);

  // cordic datapath widths: vector grows to about 2.4 * 2^32, angle to about 3.3 * 2^30
  localparam int XW = 36;
  localparam int ZW = 34;
  localparam int SH = ACC_BITS - ANGLE_FRAC_BITS;
  // error width covers des +- yaw before wrapping, whatever the angle format
  localparam int EW = (ANGLE_FRAC_BITS + 5 > 19) ? ANGLE_FRAC_BITS + 5 : 19;
  localparam int MW = 36;
  localparam int CW = $clog2(CORDIC_STEPS);

  localparam longint PI_A_L = (PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [EW-1:0] PI_A     = EW'(PI_A_L);
  localparam logic signed [EW-1:0] NEG_PI_A = EW'(-PI_A_L);
  localparam logic signed [EW-1:0] TWO_PI_A = EW'(2 * PI_A_L);
  localparam logic signed [EW-1:0] E_MAX    = EW'(32767);
  localparam logic signed [EW-1:0] E_MIN    = EW'(-32768);
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
  localparam logic signed [ZW:0]   ROUND_Z   = (ZW + 1)'(64'sd1 <<< (SH - 1));
  localparam logic [CW-1:0]        LAST_STEP = CW'(CORDIC_STEPS - 1);
  localparam logic signed [MW:0]   CMD_RND   = (MW + 1)'(2048);
  localparam logic signed [MW-12:0] CMD_MAX  = (MW - 11)'(8388607);
  localparam logic signed [MW-12:0] CMD_MIN  = (MW - 11)'(-8388608);

  // control
  yhpd_state_t state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [GAIN_CW-1:0] mcnt_r, mcnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0]  kp_r, kp_nxt, kd_r, kd_nxt;
  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;

  // payload
  logic signed [XW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic                    zero_r, zero_nxt;
  logic signed [YAW_W-1:0] yaw_r, yaw_nxt;
  logic signed [EW-1:0]    err_r, err_nxt;
  logic signed [MW-1:0]    acc_r, acc_nxt;
  logic signed [MW-1:0]    esh_r, esh_nxt, dsh_r, dsh_nxt;
  logic [GAIN_W-1:0]       kpsh_r, kpsh_nxt, kdsh_r, kdsh_nxt;
  logic signed [CMD_W-1:0] cmd_r, cmd_nxt;
  logic signed [ERR_W-1:0] herr_r, herr_nxt;

  // scratch
  logic signed [POS_W:0]   dx, dy;
  logic signed [XW-1:0]    xs, ys;
  logic signed [ZW-1:0]    at;
  logic signed [ZW:0]      zrnd;
  logic signed [EW-1:0]    des, e1, e2;
  logic signed [ERR_W:0]   dif;
  logic signed [MW:0]      cmd_full;
  logic signed [MW-12:0]   cmd_sh;
  logic                    in_fire;
  logic                    out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.yaw_rate_cmd  = cmd_r;
  assign out_ch.heading_error = herr_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = out_valid_r;
    kp_nxt        = kp_r;
    kd_nxt        = kd_r;
    last_err_nxt  = last_err_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    zero_nxt      = zero_r;
    yaw_nxt       = yaw_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    esh_nxt       = esh_r;
    dsh_nxt       = dsh_r;
    kpsh_nxt      = kpsh_r;
    kdsh_nxt      = kdsh_r;
    cmd_nxt       = cmd_r;
    herr_nxt      = herr_r;

    dx = (POS_W + 1)'(in_ch.target_x) - (POS_W + 1)'(in_ch.vehicle_x);
    dy = (POS_W + 1)'(in_ch.target_y) - (POS_W + 1)'(in_ch.vehicle_y);
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = ZW'($signed({1'b0, atan_q30(5'(cnt_r))}));
    zrnd = (ZW + 1)'(z_r) + ROUND_Z;
    des  = zero_r ? '0 : EW'(zrnd >>> SH);
    e1   = (err_r > PI_A) ? err_r - TWO_PI_A : err_r;
    e2   = (e1 < NEG_PI_A) ? e1 + TWO_PI_A : e1;
    dif  = (ERR_W + 1)'(last_err_r) - (ERR_W + 1)'(ERR_W'(err_r));
    cmd_full = (MW + 1)'(acc_r) + CMD_RND;
    cmd_sh   = (MW - 11)'(cmd_full >>> 12);

    // the output register empties on its own beat
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_idx)
        REG_KP:  kp_nxt = cfg_data;
        REG_KD:  kd_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // relative vector, exact in 33 bits
          x_nxt     = XW'(dx);
          y_nxt     = XW'(dy);
          zero_nxt  = (dx == '0) && (dy == '0);
          yaw_nxt   = in_ch.vehicle_yaw;
          state_nxt = ST_VEC;
        end
      end
      ST_VEC: begin
        // left half plane: rotate by a quarter turn toward the right half plane
        z_nxt = '0;
        if (x_r[XW-1]) begin
          if (!y_r[XW-1]) begin
            x_nxt = y_r;
            y_nxt = -x_r;
            z_nxt = HALF_PI_Z;
          end else begin
            x_nxt = -y_r;
            y_nxt = x_r;
            z_nxt = -HALF_PI_Z;
          end
        end
        cnt_nxt   = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        // one vectoring micro-rotation per cycle, driving y toward zero
        if (!y_r[XW-1]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_ANG;
        end
      end
      ST_ANG: begin
        // desired heading minus yaw, yaw taken as given
        err_nxt   = des - EW'(yaw_r);
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        // single wrap toward +-pi
        err_nxt   = e2;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (err_r > E_MAX) begin
          err_nxt = E_MAX;
        end else if (err_r < E_MIN) begin
          err_nxt = E_MIN;
        end
        state_nxt = ST_MUL;
        // the saturated value lands next cycle; load the multiplier then
      end
      ST_MUL: begin
        acc_nxt  = acc_r + (kpsh_r[0] ? esh_r : '0) + (kdsh_r[0] ? dsh_r : '0);
        esh_nxt  = esh_r <<< 1;
        dsh_nxt  = dsh_r <<< 1;
        kpsh_nxt = kpsh_r >> 1;
        kdsh_nxt = kdsh_r >> 1;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == '1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (cmd_sh > CMD_MAX) begin
            cmd_nxt = CMD_W'(CMD_MAX);
          end else if (cmd_sh < CMD_MIN) begin
            cmd_nxt = CMD_W'(CMD_MIN);
          end else begin
            cmd_nxt = CMD_W'(cmd_sh);
          end
          herr_nxt      = last_err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // multiply count starts from zero on leaving the saturation step
    if (state_r == ST_SAT) begin
      mcnt_nxt = '0;
    end
  end

  // operand load for the serial multiply happens in the cycle after saturation,
  // so the first ST_MUL cycle is spent loading (see load_r)
  logic load_r, load_nxt;

  always_comb begin
    load_nxt = (state_r == ST_SAT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      kp_r        <= KP_RESET;
      kd_r        <= KD_RESET;
      last_err_r  <= '0;
      load_r      <= 1'b0;
    end else begin
      state_r     <= (load_r) ? ST_MUL : state_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= load_r ? '0 : mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      kp_r        <= kp_nxt;
      kd_r        <= kd_nxt;
      last_err_r  <= load_r ? ERR_W'(err_r) : last_err_nxt;
      load_r      <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
    yaw_r  <= yaw_nxt;
    err_r  <= err_nxt;
    cmd_r  <= cmd_nxt;
    herr_r <= herr_nxt;
    if (load_r) begin
      // difference is previous minus current error
      acc_r  <= '0;
      esh_r  <= MW'(err_r);
      dsh_r  <= MW'(dif);
      kpsh_r <= kp_r;
      kdsh_r <= kd_r;
    end else begin
      acc_r  <= acc_nxt;
      esh_r  <= esh_nxt;
      dsh_r  <= dsh_nxt;
      kpsh_r <= kpsh_nxt;
      kdsh_r <= kdsh_nxt;
    end
  end

  // an accepted beat always starts the vector setup
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_VEC)
    else $error("accepted beat did not start vector setup");

  // a fresh result carries the error just kept for the next difference
  a_err_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> herr_r == last_err_r)
    else $error("output heading error differs from stored error");

  // all gain bits are consumed before the command is formed
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> (kpsh_r == '0) && (kdsh_r == '0))
    else $error("serial multiply left gain bits unused");

endmodule

[test/tb_yaw_heading_pd_controller.sv]
// self-checking testbench for the yaw heading pd controller with random handshake gaps
module tb_yaw_heading_pd_controller import yhpd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_SHIFT     = ACC_BITS - ANGLE_FRAC_BITS;

  // block latency plus a little margin, waited out before any gain write
  localparam int SETTLE_CYCLES  = CORDIC_STEPS + 26;
  // cycles with no beat on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0] ONE_M   = 32'sh0001_0000;
  localparam int                      YAW_PI  = 25736;

  localparam logic signed [POS_W-1:0] CORNERS [5] = '{POS_MIN, POS_MAX, 0, -1, 1};

  // atan(2^-k) in q2.30, our own copy for the heading predictor
  localparam longint ATAN_STEP [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic signed [YAW_W-1:0] yaw;
  } tick_t;

  typedef struct {
    logic signed [CMD_W-1:0] cmd;
    logic signed [ERR_W-1:0] err;
  } yaw_cmd_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = REG_KP;
  logic [GAIN_W-1:0]    cfg_data = '0;

  yhpd_in_if  in_bus ();
  yhpd_out_if out_bus ();

  yaw_heading_pd_controller #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // controller shadow state: gains and the error kept from the last tick
  logic [GAIN_W-1:0] kp_now = KP_RESET;
  logic [GAIN_W-1:0] kd_now = KD_RESET;
  longint            prev_error = 0;

  tick_t    pending_ticks [$];
  yaw_cmd_t expected_cmds [$];
  tick_t    cur_tick;

  int  ticks_sent   = 0;  // items handed to the driver
  int  results_done = 0;  // expected results matched by a result beat
  int  mismatches   = 0;
  int  in_gap       = 0;
  int  out_stall    = 0;
  int  quiet_cycles = 0;
  bit  steady       = 1'b0;  // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // q2.30 accumulator angle to output angle, round half up
  function automatic longint q30_to_angle(input longint q30);
    return (q30 + (longint'(1) <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
  endfunction

  // vectoring cordic atan2 on the exact 33-bit relative vector
  function automatic longint heading_of(input longint y_in, input longint x_in);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: pre-rotate by a quarter turn so the iterations converge
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q30;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> (i % 32);
      ys = y >>> (i % 32);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i % 32];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i % 32];
      end
    end
    return q30_to_angle(z);
  endfunction

  // heading error, pd command and the error handed on to the next tick
  function automatic void predict_yaw_cmd(input tick_t t);
    longint   pi_a;
    longint   des;
    longint   err;
    longint   dif;
    longint   acc;
    longint   cmd;
    yaw_cmd_t e;
    pi_a = q30_to_angle(PI_Q30);
    des  = heading_of(longint'(t.ty) - longint'(t.vy), longint'(t.tx) - longint'(t.vx));
    err  = des - longint'(t.yaw);
    // wrapped once each way only, yaw outside pi is taken as given
    if (err > pi_a) err = err - 2 * pi_a;
    if (err < -pi_a) err = err + 2 * pi_a;
    err = clamp(err, -32768, 32767);
    dif = prev_error - err;
    prev_error = err;
    acc = longint'(kp_now) * err + longint'(kd_now) * dif;
    cmd = clamp((acc + 2048) >>> 12, -8388608, 8388607);
    e.cmd = cmd[CMD_W-1:0];
    e.err = err[ERR_W-1:0];
    expected_cmds.push_back(e);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_tick(input logic signed [POS_W-1:0] tx, input logic signed [POS_W-1:0] ty,
                           input logic signed [POS_W-1:0] vx, input logic signed [POS_W-1:0] vy,
                           input int yaw);
    tick_t t;
    t.tx  = tx;
    t.ty  = ty;
    t.vx  = vx;
    t.vy  = vy;
    t.yaw = yaw[YAW_W-1:0];
    pending_ticks.push_back(t);
  endtask

  // random ticks: nearby targets of every scale, plus full range,
  // coincident points, axis vectors and coordinate extremes
  task automatic queue_random_ticks(input int n);
    tick_t t;
    int    kind;
    int    dx;
    int    dy;
    repeat (n) begin
      kind = $urandom_range(0, 9);
      t.vx = $urandom;
      t.vy = $urandom;
      dx   = int'($urandom) >>> $urandom_range(6, 31);
      dy   = int'($urandom) >>> $urandom_range(6, 31);
      case (kind)
        0, 1, 2: begin
          t.tx = $urandom;
          t.ty = $urandom;
        end
        7: begin
          t.tx = t.vx;
          t.ty = t.vy;
        end
        8: begin
          if ($urandom_range(0, 1)) begin
            t.tx = t.vx + dx;
            t.ty = t.vy;
          end else begin
            t.tx = t.vx;
            t.ty = t.vy + dy;
          end
        end
        9: begin
          t.tx = CORNERS[$urandom_range(0, 4)];
          t.ty = CORNERS[$urandom_range(0, 4)];
          t.vx = CORNERS[$urandom_range(0, 4)];
          t.vy = CORNERS[$urandom_range(0, 4)];
        end
        default: begin
          t.tx = t.vx + dx;
          t.ty = t.vy + dy;
        end
      endcase
      // yaw mostly within plus or minus pi, sometimes anything 16 bits holds
      if ($urandom_range(0, 4) == 0) t.yaw = YAW_W'($urandom);
      else t.yaw = YAW_W'(int'($urandom_range(0, 2 * YAW_PI)) - YAW_PI);
      pending_ticks.push_back(t);
    end
  endtask

  // wait until every tick is out and checked, then let the block settle
  task automatic drain();
    while (pending_ticks.size() != 0 || results_done != ticks_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KP) kp_now = data;
    else if (idx == REG_KD) kd_now = data;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd);
    write_reg(REG_KP, kp);
    write_reg(REG_KD, kd);
  endtask

  // input side driver: holds each beat until taken, then an optional gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap       <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) predict_yaw_cmd(cur_tick);
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap != 0) begin
          in_gap       <= in_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          cur_tick = pending_ticks.pop_front();
          ticks_sent++;
          in_bus.target_x    <= cur_tick.tx;
          in_bus.target_y    <= cur_tick.ty;
          in_bus.vehicle_x   <= cur_tick.vx;
          in_bus.vehicle_y   <= cur_tick.vy;
          in_bus.vehicle_yaw <= cur_tick.yaw;
          in_bus.valid       <= 1'b1;
          in_gap             <= pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stalls on ready, every result beat checked in order
  always @(posedge clk) begin
    yaw_cmd_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall     <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: cmd %0d err %0d",
                                    out_bus.yaw_rate_cmd, out_bus.heading_error));
        end else begin
          want = expected_cmds.pop_front();
          if (out_bus.yaw_rate_cmd !== want.cmd)
            report_mismatch($sformatf("beat %0d yaw_rate_cmd got %0d expected %0d",
                                      results_done, out_bus.yaw_rate_cmd, want.cmd));
          if (out_bus.heading_error !== want.err)
            report_mismatch($sformatf("beat %0d heading_error got %0d expected %0d",
                                      results_done, out_bus.heading_error, want.err));
          results_done++;
        end
      end
      if (out_stall != 0) begin
        out_stall     <= out_stall - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
      end
    end
  end

  // hang detector: too long with no beat on either channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.target_x    = '0;
    in_bus.target_y    = '0;
    in_bus.vehicle_x   = '0;
    in_bus.vehicle_y   = '0;
    in_bus.vehicle_yaw = '0;
    out_bus.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains, directed corners first
    // coincident points give zero heading
    push_tick(0, 0, 0, 0, 0);
    push_tick(POS_MAX, POS_MIN, POS_MAX, POS_MIN, YAW_PI);
    push_tick(-5, 7, -5, 7, -YAW_PI);
    // the four axis directions
    push_tick(ONE_M, 0, 0, 0, 0);
    push_tick(0, ONE_M, 0, 0, 0);
    push_tick(0, -ONE_M, 0, 0, 0);
    push_tick(-ONE_M, 0, 0, 0, 0);
    // negative x axis is plus pi, with yaw at minus pi the error wraps to zero
    push_tick(-ONE_M, 0, 0, 0, -YAW_PI);
    push_tick(-ONE_M, 0, 0, 0, 32767);
    // both left quadrants, pre-rotated each way
    push_tick(-100, 100, 0, 0, 0);
    push_tick(-100, -100, 0, 0, 0);
    // wrap from below, and yaw outside plus or minus pi on both sides
    push_tick(ONE_M, -ONE_M, 0, 0, YAW_PI);
    push_tick(-ONE_M, 1, 0, 0, -32768);
    push_tick(-ONE_M, -1, 0, 0, 32767);
    // largest relative vectors in all four diagonal directions
    push_tick(POS_MAX, POS_MAX, POS_MIN, POS_MIN, 0);
    push_tick(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 0);
    push_tick(POS_MIN, POS_MAX, POS_MAX, POS_MIN, 0);
    push_tick(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 0);
    // unit vectors and a longest vector on the negative x axis
    push_tick(1, 0, 0, 0, 0);
    push_tick(0, 0, 1, 1, 0);
    push_tick(0, 1, 0, 0, -1);
    push_tick(POS_MIN, 0, POS_MAX, 0, YAW_PI);
    queue_random_ticks(150);
    drain();

    // full gains, error swinging between the extremes for the largest difference term
    set_gains(16'hffff, 16'hffff);
    push_tick(ONE_M, 0, 0, 0, YAW_PI);
    push_tick(-ONE_M, 0, 0, 0, 0);
    push_tick(ONE_M, 0, 0, 0, YAW_PI);
    push_tick(-ONE_M, 0, 0, 0, 0);
    queue_random_ticks(225);
    drain();

    // both gains zero, no idling on either side
    steady = 1'b1;
    set_gains(16'h0000, 16'h0000);
    queue_random_ticks(150);
    drain();
    steady = 1'b0;

    // derivative only; writes to the spare indexes must not touch the gains
    set_gains(16'h0000, 16'hffff);
    write_reg(REG_SPARE_A, GAIN_W'($urandom));
    write_reg(REG_SPARE_B, GAIN_W'($urandom));
    queue_random_ticks(200);
    drain();

    set_gains(GAIN_W'($urandom), GAIN_W'($urandom));
    queue_random_ticks(200);
    drain();

    // unity proportional gain, smallest nonzero derivative gain
    set_gains(16'h1000, 16'h0001);
    queue_random_ticks(200);
    drain();

    if (expected_cmds.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_cmds.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
